FILE: hdl/pbts_pkg.sv
// Package for the priority bitmap task scheduler.
// Holds sizes, link markers and operation codes; no dependencies.
package pbts_pkg;

  localparam int NumTasks  = 64;
  localparam int NumLevels = 32;
  localparam int TaskW     = $clog2(NumTasks);
  localparam int PtrW      = TaskW + 1;
  localparam int LvlW      = $clog2(NumLevels);
  localparam int TimeW     = 48;
  localparam int RefillW   = 47;
  localparam int CntW      = 7;

  localparam logic [PtrW-1:0] NilPtr = PtrW'(NumTasks);

  typedef enum logic [2:0] {
    OP_ARRIVE  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REQUEUE = 3'd2,
    OP_PICK    = 3'd3,
    OP_PUTPREV = 3'd4,
    OP_PREEMPT = 3'd5
  } op_e;

endpackage

FILE: hdl/pbts_in_if.sv
// Command channel of the task scheduler: valid/ready plus the command word.
// Depends on pbts_pkg.
interface pbts_in_if;
  import pbts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           op;
  logic [TaskW-1:0]     task_id;
  logic [LvlW-1:0]      priority_req;
  logic [RefillW-1:0]   refill_budget;
  logic                 at_head;
  logic [TimeW-1:0]     now;
  modport source (output valid, op, task_id, priority_req, refill_budget, at_head, now,
                  input ready);
  modport sink   (input valid, op, task_id, priority_req, refill_budget, at_head, now,
                  output ready);
endinterface

FILE: hdl/pbts_out_if.sv
// Result channel of the task scheduler: valid/ready plus the result word.
// Depends on pbts_pkg.
interface pbts_out_if;
  import pbts_pkg::*;
  logic                valid;
  logic                ready;
  logic [TaskW-1:0]    picked_task;
  logic                picked_valid;
  logic                resched;
  logic                exhausted;
  logic signed [TimeW-1:0] budget_left;
  logic [CntW-1:0]     ready_count;
  modport source (output valid, picked_task, picked_valid, resched, exhausted, budget_left,
                  ready_count, input ready);
  modport sink   (input valid, picked_task, picked_valid, resched, exhausted, budget_left,
                  ready_count, output ready);
endinterface

FILE: hdl/priority_bitmap_task_scheduler_unit.sv
// Priority bitmap task scheduler: per-level FIFOs as linked lists in per-task memories.
// Depends on pbts_pkg, pbts_in_if, pbts_out_if.
//
// Usage: one command word enters on in_i, one result word leaves on out_o
// for every command. Commands are arrive, remove, requeue, pick, put_prev
// and preempt check. Link, level, budget and start-time tables sit in
// single-port-write memories with a registered read, issued
// when a word is accepted.
// Steps after accept: read, done for pick, preempt check, remove, ignored
// and undefined ops; read, budget change, done for put_prev; read, link,
// optional second link, done for arrive and requeue that act on the task.
// The sequencer handles one word at a time and takes no word until idle.
// Reset clears level heads/tails, ready bitmap, queued flags, count and
// current task at once; no clearing pass is needed.
// A finished result waits in the output register; a stalled receiver
// holds the sequencer in its final step, and in_i.ready stays low.
module priority_bitmap_task_scheduler_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbts_in_if.sink    in_i,
  pbts_out_if.source out_o
);
  import pbts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_LINK1 = 3'd2;
  localparam logic [2:0] S_LINK2 = 3'd3;
  localparam logic [2:0] S_CHG   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic signed [TimeW-1:0] BudMin = {1'b1, {(TimeW-1){1'b0}}};

  logic [2:0] state_q, state_d;

  logic [PtrW-1:0] head_q [NumLevels];
  logic [PtrW-1:0] head_d [NumLevels];
  logic [PtrW-1:0] tail_q [NumLevels];
  logic [PtrW-1:0] tail_d [NumLevels];
  logic [NumLevels-1:0] rdy_q, rdy_d;
  logic [NumTasks-1:0]  qf_q, qf_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PtrW-1:0]      cur_q, cur_d;

  logic [PtrW-1:0]  nxt_mem [NumTasks];
  logic [PtrW-1:0]  prv_mem [NumTasks];
  logic [LvlW-1:0]  lvl_mem [NumTasks];
  logic [TimeW-1:0] bud_mem [NumTasks];
  logic [TimeW-1:0] st_mem  [NumTasks];

  logic [PtrW-1:0]  rd_nxt_q, rd_prv_q;
  logic [LvlW-1:0]  rd_lvl_q;
  logic [TimeW-1:0] rd_bud_q, rd_st_q;
  logic [TaskW-1:0] rd_addr;

  logic             nxt_we, prv_we, lvl_we, bud_we, st_we;
  logic [TaskW-1:0] nxt_wa, prv_wa, st_wa;
  logic [PtrW-1:0]  nxt_wd, prv_wd;
  logic [TimeW-1:0] bud_wd, st_wd;

  logic [2:0]         op_q;
  logic [TaskW-1:0]   tid_q;
  logic [LvlW-1:0]    lvl_q;
  logic [RefillW-1:0] ref_q;
  logic               hd_q;
  logic [TimeW-1:0]   now_q;

  logic             l2_prv_q, l2_prv_d;
  logic [TaskW-1:0] l2_addr_q, l2_addr_d;
  logic [TimeW-1:0] bnew_q, bnew_d;

  logic [TaskW-1:0] res_pick_q, res_pick_d;
  logic             res_pv_q, res_pv_d, res_rs_q, res_rs_d, res_ex_q, res_ex_d;
  logic [TimeW-1:0] res_bl_q, res_bl_d;

  logic             ov_q;
  logic             in_acc, out_load;

  logic             do_unlink, do_link;
  logic [LvlW-1:0]  lk_lvl;
  logic             lk_head;
  logic [PtrW-1:0]  tid_ptr, ul_newhead, lk_h, lk_e;
  logic             ul_pv, ul_nv;
  logic             pk_found;
  logic [LvlW-1:0]  pk_lvl;
  logic [TimeW-1:0] delta, room;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!ov_q || out_o.ready);
  assign rd_addr  = (op_e'(in_i.op) == OP_PREEMPT) ? cur_q[TaskW-1:0] : in_i.task_id;
  assign tid_ptr  = {1'b0, tid_q};

  // lowest set ready bit
  always_comb begin
    pk_found = 1'b0;
    pk_lvl   = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (rdy_q[i]) begin
        pk_found = 1'b1;
        pk_lvl   = LvlW'(i);
      end
    end
  end

  assign ul_pv      = rd_prv_q < NilPtr;
  assign ul_nv      = rd_nxt_q < NilPtr;
  assign ul_newhead = ul_pv ? head_q[rd_lvl_q] : rd_nxt_q;
  assign lk_lvl     = (op_e'(op_q) == OP_ARRIVE) ? lvl_q : rd_lvl_q;
  assign lk_head    = (op_e'(op_q) == OP_REQUEUE) && hd_q;
  assign lk_h       = head_q[lk_lvl];
  assign lk_e       = tail_q[lk_lvl];
  assign delta      = now_q - rd_st_q;
  assign room       = {~rd_bud_q[TimeW-1], rd_bud_q[TimeW-2:0]};

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    rdy_d    = rdy_q;
    qf_d     = qf_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    l2_prv_d = l2_prv_q;
    l2_addr_d = l2_addr_q;
    bnew_d   = bnew_q;
    res_pick_d = res_pick_q;
    res_pv_d = res_pv_q;
    res_rs_d = res_rs_q;
    res_ex_d = res_ex_q;
    res_bl_d = res_bl_q;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    lvl_we = 1'b0; bud_we = 1'b0; bud_wd = '0;
    st_we  = 1'b0; st_wa  = '0; st_wd  = '0;
    do_unlink = 1'b0;
    do_link   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d    = S_RD;
          res_pick_d = '0;
          res_pv_d   = 1'b0;
          res_rs_d   = 1'b0;
          res_ex_d   = 1'b0;
          res_bl_d   = '0;
        end
      end
      S_RD: begin
        state_d = S_DONE;
        case (op_e'(op_q))
          OP_ARRIVE: begin
            if (!qf_q[tid_q]) begin
              lvl_we  = 1'b1;
              bud_we  = 1'b1;
              bud_wd  = {1'b0, ref_q};
              qf_d[tid_q] = 1'b1;
              cnt_d   = cnt_q + 1'b1;
              state_d = S_LINK1;
            end
          end
          OP_REMOVE: begin
            if (qf_q[tid_q]) begin
              do_unlink   = 1'b1;
              qf_d[tid_q] = 1'b0;
              if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            end
          end
          OP_REQUEUE: begin
            if (qf_q[tid_q]) begin
              do_unlink = 1'b1;
              state_d   = S_LINK1;
            end
          end
          OP_PICK: begin
            cur_d = NilPtr;
            if (pk_found) begin
              cur_d      = head_q[pk_lvl];
              st_we      = 1'b1;
              st_wa      = head_q[pk_lvl][TaskW-1:0];
              st_wd      = now_q;
              res_pick_d = head_q[pk_lvl][TaskW-1:0];
              res_pv_d   = 1'b1;
            end
          end
          OP_PUTPREV: begin
            bnew_d  = (delta > room) ? BudMin : rd_bud_q - delta;
            state_d = S_CHG;
          end
          OP_PREEMPT: begin
            res_rs_d = (cur_q >= NilPtr) || (lvl_q < rd_lvl_q);
          end
          default: ;
        endcase
      end
      S_LINK1: begin
        do_link = 1'b1;
      end
      S_LINK2: begin
        if (l2_prv_q) begin
          prv_we = 1'b1; prv_wa = l2_addr_q; prv_wd = tid_ptr;
        end else begin
          nxt_we = 1'b1; nxt_wa = l2_addr_q; nxt_wd = tid_ptr;
        end
        state_d = S_DONE;
      end
      S_CHG: begin
        bud_we   = 1'b1;
        bud_wd   = bnew_q;
        st_we    = 1'b1;
        st_wa    = tid_q;
        st_wd    = now_q;
        res_bl_d = bnew_q;
        if ((bnew_q[TimeW-1] || bnew_q == '0) && qf_q[tid_q]) begin
          do_unlink   = 1'b1;
          qf_d[tid_q] = 1'b0;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
          res_ex_d    = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (do_unlink) begin
      if (ul_pv) begin
        nxt_we = 1'b1; nxt_wa = rd_prv_q[TaskW-1:0]; nxt_wd = rd_nxt_q;
      end else begin
        head_d[rd_lvl_q] = rd_nxt_q;
      end
      if (ul_nv) begin
        prv_we = 1'b1; prv_wa = rd_nxt_q[TaskW-1:0]; prv_wd = rd_prv_q;
      end else begin
        tail_d[rd_lvl_q] = rd_prv_q;
      end
      rdy_d[rd_lvl_q] = ul_newhead < NilPtr;
    end

    if (do_link) begin
      state_d = S_DONE;
      nxt_we  = 1'b1; nxt_wa = tid_q;
      prv_we  = 1'b1; prv_wa = tid_q;
      if (lk_head) begin
        prv_wd = NilPtr;
        nxt_wd = lk_h;
        if (lk_h < NilPtr) begin
          l2_prv_d  = 1'b1;
          l2_addr_d = lk_h[TaskW-1:0];
          state_d   = S_LINK2;
        end else begin
          tail_d[lk_lvl] = tid_ptr;
        end
        head_d[lk_lvl] = tid_ptr;
      end else begin
        nxt_wd = NilPtr;
        prv_wd = lk_e;
        if (lk_e < NilPtr) begin
          l2_prv_d  = 1'b0;
          l2_addr_d = lk_e[TaskW-1:0];
          state_d   = S_LINK2;
        end else begin
          head_d[lk_lvl] = tid_ptr;
        end
        tail_d[lk_lvl] = tid_ptr;
      end
      rdy_d[lk_lvl] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= NilPtr;
        tail_q[i] <= NilPtr;
      end
      rdy_q <= '0;
      qf_q  <= '0;
      cnt_q <= '0;
      cur_q <= NilPtr;
      ov_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      rdy_q   <= rdy_d;
      qf_q    <= qf_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      if (out_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.op;
      tid_q <= in_i.task_id;
      lvl_q <= in_i.priority_req;
      ref_q <= in_i.refill_budget;
      hd_q  <= in_i.at_head;
      now_q <= in_i.now;
    end
    l2_prv_q   <= l2_prv_d;
    l2_addr_q  <= l2_addr_d;
    bnew_q     <= bnew_d;
    res_pick_q <= res_pick_d;
    res_pv_q   <= res_pv_d;
    res_rs_q   <= res_rs_d;
    res_ex_q   <= res_ex_d;
    res_bl_q   <= res_bl_d;
    if (out_load) begin
      out_o.picked_task  <= res_pick_q;
      out_o.picked_valid <= res_pv_q;
      out_o.resched      <= res_rs_q;
      out_o.exhausted    <= res_ex_q;
      out_o.budget_left  <= res_bl_q;
      out_o.ready_count  <= cnt_q;
    end
  end

  assign out_o.valid = ov_q;

  // task memories
  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (lvl_we) lvl_mem[tid_q] <= lvl_q;
    if (bud_we) bud_mem[tid_q] <= bud_wd;
    if (st_we)  st_mem[st_wa]  <= st_wd;
    if (in_acc) begin
      rd_nxt_q <= nxt_mem[rd_addr];
      rd_prv_q <= prv_mem[rd_addr];
      rd_lvl_q <= lvl_mem[rd_addr];
      rd_bud_q <= bud_mem[rd_addr];
      rd_st_q  <= st_mem[rd_addr];
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NumTasks)) else $error("queued count out of range");

  a_empty_bitmap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rdy_q == '0)) else $error("ready bit set with no queued task");

  a_link2_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK2) |-> ($past(state_q) == S_LINK1)) else $error("bad link sequence");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(cnt_q)) else $error("count changed while idle");

endmodule
